// ===== rtl/iiee_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants and types for the infix expression evaluator.
// No dependencies; used by the interfaces, the divider and the top level.
package iiee_pkg;

  localparam int WORD_BITS = 32;
  localparam int OUT_BITS  = 32;
  localparam int CHAR_BITS = 8;

  localparam logic [CHAR_BITS-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_BITS-1:0] CH_STAR  = 8'h2A;
  localparam logic [CHAR_BITS-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_BITS-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_BITS-1:0] CH_SLASH = 8'h2F;
  localparam logic [CHAR_BITS-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_BITS-1:0] CH_NINE  = 8'h39;

  typedef struct packed {
    logic                 start;
    logic [WORD_BITS-1:0] dividend;
    logic [WORD_BITS-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [WORD_BITS-1:0] quotient;
  } div_rsp_t;

endpackage

// ===== rtl/iiee_in_if.sv =====
`timescale 1ns / 1ps
// Character request channel: valid/ready handshake with ch and last.
// Depends on iiee_pkg.
interface iiee_in_if;
  logic                          valid;
  logic                          ready;
  logic [iiee_pkg::CHAR_BITS-1:0] ch;
  logic                          last;

  modport source (output valid, output ch, output last, input ready);
  modport sink   (input valid, input ch, input last, output ready);
endinterface

// ===== rtl/iiee_out_if.sv =====
`timescale 1ns / 1ps
// Result request channel: valid/ready handshake with value and error.
// Depends on iiee_pkg.
interface iiee_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [iiee_pkg::OUT_BITS-1:0] value;
  logic                                error;

  modport source (output valid, output value, output error, input ready);
  modport sink   (input valid, input value, input error, output ready);
endinterface

// ===== rtl/infix_integer_expression_evaluator.sv =====
`timescale 1ns / 1ps
// Top level of the streaming infix expression evaluator.
// Depends on iiee_pkg, iiee_in_if, iiee_out_if and iiee_div.
//
// Usage:
//   din carries one ASCII character per request (ch) with last set on the
//   final character. dout carries one request per expression: value and
//   error, with value forced to zero on error.
//   Spaces are skipped, + - * / follow the usual precedence, each atom may
//   carry one leading minus, arithmetic wraps at 32 bits.
// Timing:
//   Outside a divide, din.ready is held low only by a waiting result. A fold into a
//   pending divide runs the shared radix-2 divider: a launch, 32 bit steps
//   and a retire, with din.ready low meanwhile.
//   The result appears on dout in the cycle after the last character (or
//   after the divider retires when the last atom is a divisor).
// Reset:
//   rst clears all parse state and drops any pending result.
// Backpressure:
//   The result sits in an output register; while it waits din.ready follows
//   dout.ready, so the next character is taken in the cycle the result leaves.
module infix_integer_expression_evaluator (
  input logic        clk,
  input logic        rst,
  iiee_in_if.sink    din,
  iiee_out_if.source dout
);

  localparam int W        = iiee_pkg::WORD_BITS;
  localparam int MAG_BITS = W - 1;
  localparam int ACC_BITS = W + 3;
  localparam logic [W-1:0] LIT_MAX = {1'b0, {(W-1){1'b1}}};

  typedef enum logic {ST_IDLE, ST_DIV} state_t;
  typedef enum logic [1:0] {PH_ATOM, PH_SIGN, PH_DIGITS} phase_t;
  typedef enum logic [1:0] {MUL_NONE, MUL_TIMES, MUL_DIVIDE} mul_t;

  state_t                           state, state_next;
  logic [W-1:0]                     sum, sum_next;
  logic [W-1:0]                     term, term_next;
  logic                             add_pend, add_pend_next;
  mul_t                             mul_pend, mul_pend_next;
  logic [MAG_BITS-1:0]              mag, mag_next;
  logic                             neg, neg_next;
  phase_t                           phase, phase_next;
  logic                             err_seen, err_seen_next;
  logic [iiee_pkg::CHAR_BITS-1:0]   op_save, op_save_next;
  logic                             last_save, last_save_next;
  logic                             out_valid, out_valid_next;
  logic signed [iiee_pkg::OUT_BITS-1:0] out_value, out_value_next;
  logic                             out_error, out_error_next;

  iiee_pkg::div_req_t div_req;
  iiee_pkg::div_rsp_t div_rsp;
  logic               div_start;

  logic                accept;
  logic                is_digit, is_space, is_op;
  logic [ACC_BITS-1:0] acc10;
  logic                lit_ovf;
  logic                t_err, t_neg;
  logic [MAG_BITS-1:0] t_mag;
  phase_t              t_phase;
  logic [W-1:0]        fold_val;
  logic [W-1:0]        prod_full;
  logic [W-1:0]        fold_term;
  logic                fin_go, fin_last;
  logic [iiee_pkg::CHAR_BITS-1:0] fin_op;
  logic [W-1:0]        fin_term, fin_sum;

  iiee_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign din.ready  = (state == ST_IDLE) && (!out_valid || dout.ready);
  assign accept     = din.valid && din.ready;
  assign dout.valid = out_valid;
  assign dout.value = out_value;
  assign dout.error = out_error;

  assign is_digit = (din.ch >= iiee_pkg::CH_ZERO) && (din.ch <= iiee_pkg::CH_NINE);
  assign is_space = (din.ch == iiee_pkg::CH_SPACE);
  assign is_op    = (din.ch == iiee_pkg::CH_PLUS) || (din.ch == iiee_pkg::CH_MINUS) ||
                    (din.ch == iiee_pkg::CH_STAR) || (din.ch == iiee_pkg::CH_SLASH);

  // mag * 10 + digit, checked against the largest literal
  assign acc10   = ACC_BITS'({mag, 3'b000}) + ACC_BITS'({mag, 1'b0}) +
                   ACC_BITS'(din.ch[3:0]);
  assign lit_ovf = acc10 > ACC_BITS'(LIT_MAX);

  // number state after taking the character, before any fold
  always_comb begin
    t_err   = 1'b0;
    t_mag   = mag;
    t_neg   = neg;
    t_phase = phase;
    if (!is_space) begin
      if (phase != PH_DIGITS) begin
        if (is_digit) begin
          t_mag   = MAG_BITS'(din.ch[3:0]);
          t_phase = PH_DIGITS;
        end else if (phase == PH_ATOM && din.ch == iiee_pkg::CH_MINUS) begin
          t_neg   = 1'b1;
          t_phase = PH_SIGN;
        end else begin
          t_err = 1'b1;
        end
      end else if (is_digit) begin
        if (lit_ovf) t_err = 1'b1;
        else         t_mag = acc10[MAG_BITS-1:0];
      end else if (!is_op) begin
        t_err = 1'b1;
      end
    end
  end

  assign fold_val  = t_neg ? (W'(0) - {1'b0, t_mag}) : {1'b0, t_mag};
  assign prod_full = term * fold_val;
  assign fold_term = (mul_pend == MUL_TIMES) ? prod_full : fold_val;

  assign div_req.start    = div_start;
  assign div_req.dividend = term;
  assign div_req.divisor  = fold_val;

  assign fin_sum = add_pend ? (sum - fin_term) : (sum + fin_term);

  always_comb begin
    state_next     = state;
    sum_next       = sum;
    term_next      = term;
    add_pend_next  = add_pend;
    mul_pend_next  = mul_pend;
    mag_next       = mag;
    neg_next       = neg;
    phase_next     = phase;
    err_seen_next  = err_seen;
    op_save_next   = op_save;
    last_save_next = last_save;
    out_valid_next = out_valid && !dout.ready;
    out_value_next = out_value;
    out_error_next = out_error;
    div_start      = 1'b0;
    fin_go         = 1'b0;
    fin_last       = 1'b0;
    fin_op         = din.ch;
    fin_term       = fold_term;

    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          priority if (err_seen) begin
            if (din.last) begin
              out_valid_next = 1'b1;
              out_error_next = 1'b1;
            end
          end else if (din.last && (t_err || is_op || t_phase != PH_DIGITS)) begin
            out_valid_next = 1'b1;
            out_error_next = 1'b1;
          end else if (t_err) begin
            err_seen_next = 1'b1;
          end else if (din.last || (is_op && phase == PH_DIGITS)) begin
            if (mul_pend == MUL_DIVIDE) begin
              if (t_mag == '0) begin
                if (din.last) begin
                  out_valid_next = 1'b1;
                  out_error_next = 1'b1;
                end else begin
                  err_seen_next = 1'b1;
                end
              end else begin
                div_start      = 1'b1;
                op_save_next   = din.ch;
                last_save_next = din.last;
                state_next     = ST_DIV;
              end
            end else begin
              fin_go   = 1'b1;
              fin_last = din.last;
            end
          end else begin
            mag_next   = t_mag;
            neg_next   = t_neg;
            phase_next = t_phase;
          end
        end
      end
      ST_DIV: begin
        fin_op   = op_save;
        fin_term = div_rsp.quotient;
        if (div_rsp.done) begin
          fin_go     = 1'b1;
          fin_last   = last_save;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase

    // retire the folded atom: emit on the final character, else apply the operator
    if (fin_go) begin
      if (fin_last) begin
        out_valid_next = 1'b1;
        out_error_next = 1'b0;
        out_value_next = iiee_pkg::OUT_BITS'(fin_sum);
      end else begin
        term_next  = fin_term;
        mag_next   = '0;
        neg_next   = 1'b0;
        phase_next = PH_ATOM;
        priority if (fin_op == iiee_pkg::CH_STAR) begin
          mul_pend_next = MUL_TIMES;
        end else if (fin_op == iiee_pkg::CH_SLASH) begin
          mul_pend_next = MUL_DIVIDE;
        end else begin
          sum_next      = fin_sum;
          add_pend_next = (fin_op == iiee_pkg::CH_MINUS);
          mul_pend_next = MUL_NONE;
        end
      end
    end

    // an emitted result ends the expression: drop all parse state
    if (out_valid_next && !(out_valid && !dout.ready)) begin
      sum_next      = '0;
      term_next     = '0;
      add_pend_next = 1'b0;
      mul_pend_next = MUL_NONE;
      mag_next      = '0;
      neg_next      = 1'b0;
      phase_next    = PH_ATOM;
      err_seen_next = 1'b0;
      if (out_error_next) out_value_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      sum       <= '0;
      term      <= '0;
      add_pend  <= 1'b0;
      mul_pend  <= MUL_NONE;
      mag       <= '0;
      neg       <= 1'b0;
      phase     <= PH_ATOM;
      err_seen  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      sum       <= sum_next;
      term      <= term_next;
      add_pend  <= add_pend_next;
      mul_pend  <= mul_pend_next;
      mag       <= mag_next;
      neg       <= neg_next;
      phase     <= phase_next;
      err_seen  <= err_seen_next;
      out_valid <= out_valid_next;
    end
    op_save   <= op_save_next;
    last_save <= last_save_next;
    out_value <= out_value_next;
    out_error <= out_error_next;
  end

endmodule

// ===== rtl/iiee_div.sv =====
`timescale 1ns / 1ps
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
// Depends on iiee_pkg for the word width and the request/response structs.
module iiee_div (
  input  logic               clk,
  input  logic               rst,
  input  iiee_pkg::div_req_t req,
  output iiee_pkg::div_rsp_t rsp
);

  localparam int W        = iiee_pkg::WORD_BITS;
  localparam int CNT_BITS = $clog2(W);
  localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(W - 1);

  logic                busy;
  logic                done;
  logic [CNT_BITS-1:0] cnt;
  logic [W-1:0]        rem;
  logic [W-1:0]        quo;
  logic [W-1:0]        dvs;
  logic                neg_q;

  logic         sa, sb;
  logic [W-1:0] ma, mb;
  logic [W:0]   shifted, diff;
  logic         qbit;
  logic [W-1:0] rem_next;

  assign sa = req.dividend[W-1];
  assign sb = req.divisor[W-1];
  // magnitude of the most negative value reads correctly as unsigned
  assign ma = sa ? (W'(0) - req.dividend) : req.dividend;
  assign mb = sb ? (W'(0) - req.divisor) : req.divisor;

  assign shifted  = {rem, quo[W-1]};
  assign diff     = shifted - {1'b0, dvs};
  assign qbit     = ~diff[W];
  assign rem_next = qbit ? diff[W-1:0] : shifted[W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy  <= 1'b1;
        cnt   <= '0;
        rem   <= '0;
        quo   <= ma;
        dvs   <= mb;
        neg_q <= sa ^ sb;
      end else if (busy) begin
        rem <= rem_next;
        quo <= {quo[W-2:0], qbit};
        cnt <= cnt + CNT_BITS'(1);
        if (cnt == CNT_LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = neg_q ? (W'(0) - quo) : quo;

endmodule
